// File: rtl/core/scc_pkg.sv
// Shared widths, defaults and register indexes for the SCC counter.
// No dependencies; every other file refers to it by scoped name.
package scc_pkg;
    localparam int MAX_NODES_DEF    = 64;
    localparam int NODE_W           = 6;
    localparam int COUNT_W          = 7;
    localparam int CFG_DATA_W       = 7;
    localparam int CFG_INDEX_W      = 1;
    localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 7'd64;

    localparam logic [CFG_INDEX_W-1:0] REG_NODE_COUNT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_UNDIRECTED = 1'd1;
endpackage

// File: rtl/core/scc_if.sv
// Valid/ready channel interfaces for edge beats and count beats.
// Depends on scc_pkg for field widths.
interface scc_edge_if;
    logic                       valid;
    logic                       ready;
    logic [scc_pkg::NODE_W-1:0] edge_src;
    logic [scc_pkg::NODE_W-1:0] edge_dst;
    logic                       edge_valid;
    logic                       last_edge;

    modport source (output valid, edge_src, edge_dst, edge_valid, last_edge, input ready);
    modport sink   (input valid, edge_src, edge_dst, edge_valid, last_edge, output ready);
endinterface

interface scc_count_if;
    logic                        valid;
    logic                        ready;
    logic [scc_pkg::COUNT_W-1:0] component_count;

    modport source (output valid, component_count, input ready);
    modport sink   (input valid, component_count, output ready);
endinterface

// File: rtl/core/strongly_connected_component_count_top.sv
// SCC counter top level: adjacency memories, walk stack and Kosaraju sequencer.
// Depends on scc_pkg and the channel interfaces in scc_if.sv.
// A directed edge is one row read and write; an undirected edge repeats it swapped.
// A count walks each node in each pass with a row read, a scan and a pop,
// and steps over each node index in pass one and each finish entry in pass two.
// One beat is in work at a time; a finished count waits in the output register.
// Reset clears control state and the row valid bits, so both matrices read as zero;
// the row valid bits are dropped again after each count, with no clearing pass.
module strongly_connected_component_count_top #(
    parameter int MAX_NODES = scc_pkg::MAX_NODES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    scc_edge_if.sink                        edge_in,
    scc_count_if.source                     count_out,
    input  logic                            cfg_we,
    input  logic [scc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [scc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    localparam int NW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_LRD, S_LWR, S_CINIT, S_P1, S_ROW, S_SCAN, S_POP, S_P2, S_P2W, S_DONE
    } state_t;

    state_t state_reg;

    logic [MAX_NODES-1:0] fwd_mem [MAX_NODES];
    logic [MAX_NODES-1:0] rev_mem [MAX_NODES];
    logic [NW-1:0]        stack_mem [MAX_NODES];
    logic [NW-1:0]        finish_mem [MAX_NODES];

    logic [MAX_NODES-1:0] fwd_rv_reg, rev_rv_reg;
    logic [MAX_NODES-1:0] fwd_rdata_reg, rev_rdata_reg;
    logic                 fwd_rvld_reg, rev_rvld_reg;
    logic [NW-1:0]        stack_rdata_reg, finish_rdata_reg;

    logic [scc_pkg::COUNT_W-1:0] node_count_reg;
    logic                        undirected_reg;

    logic [NW-1:0]        a_reg, b_reg, top_reg;
    logic                 und_reg, second_reg, last_reg, pass2_reg;
    logic [MAX_NODES-1:0] visited_reg;
    logic [CW-1:0]        n_reg, i_reg, j_reg, depth_reg, fc_reg, tree_reg;
    logic                 out_valid_reg;
    logic [scc_pkg::COUNT_W-1:0] out_count_reg;

    logic [NW-1:0]        fwd_raddr, rev_raddr, stack_raddr, finish_raddr;
    logic [MAX_NODES-1:0] used_mask, row, cand;
    logic                 found;
    logic [NW-1:0]        low_idx;
    logic                 edge_ok;

    function automatic logic [NW-1:0] lowest(input logic [MAX_NODES-1:0] v);
        logic [NW-1:0] res;
        res = '0;
        for (int k = MAX_NODES - 1; k >= 0; k--)
        begin
            if (v[k])
            begin
                res = NW'(k);
            end
        end
        return res;
    endfunction

    assign edge_in.ready             = (state_reg == S_IDLE);
    assign count_out.valid           = out_valid_reg;
    assign count_out.component_count = out_count_reg;

    assign edge_ok = edge_in.edge_valid && (32'(edge_in.edge_src) < MAX_NODES)
                     && (32'(edge_in.edge_dst) < MAX_NODES);

    always_comb
    begin
        for (int k = 0; k < MAX_NODES; k++)
        begin
            used_mask[k] = (k < 32'(n_reg));
        end
        if (pass2_reg)
        begin
            row = rev_rvld_reg ? rev_rdata_reg : '0;
        end
        else
        begin
            row = fwd_rvld_reg ? fwd_rdata_reg : '0;
        end
        cand         = row & ~visited_reg & used_mask;
        found        = |cand;
        low_idx      = lowest(cand);
        fwd_raddr    = (state_reg == S_LRD) ? a_reg : top_reg;
        rev_raddr    = (state_reg == S_LRD) ? b_reg : top_reg;
        stack_raddr  = NW'(depth_reg - CW'(2));
        finish_raddr = NW'(fc_reg - CW'(1) - j_reg);
    end

    always_ff @(posedge clk)
    begin
        fwd_rdata_reg    <= fwd_mem[fwd_raddr];
        rev_rdata_reg    <= rev_mem[rev_raddr];
        stack_rdata_reg  <= stack_mem[stack_raddr];
        finish_rdata_reg <= finish_mem[finish_raddr];
        if (state_reg == S_LWR)
        begin
            fwd_mem[a_reg] <= (fwd_rvld_reg ? fwd_rdata_reg : '0)
                              | (MAX_NODES'(1) << b_reg);
            rev_mem[b_reg] <= (rev_rvld_reg ? rev_rdata_reg : '0)
                              | (MAX_NODES'(1) << a_reg);
        end
        if (state_reg == S_SCAN && found && 32'(depth_reg) < MAX_NODES)
        begin
            stack_mem[NW'(depth_reg - CW'(1))] <= top_reg;
        end
        if (state_reg == S_SCAN && !(found && 32'(depth_reg) < MAX_NODES)
            && !pass2_reg && 32'(fc_reg) < MAX_NODES)
        begin
            finish_mem[NW'(fc_reg)] <= top_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fwd_rv_reg     <= '0;
            rev_rv_reg     <= '0;
            fwd_rvld_reg   <= 1'b0;
            rev_rvld_reg   <= 1'b0;
            node_count_reg <= scc_pkg::NODE_COUNT_RESET;
            undirected_reg <= 1'b0;
            visited_reg    <= '0;
            depth_reg      <= '0;
            fc_reg         <= '0;
            tree_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_count_reg  <= '0;
            second_reg     <= 1'b0;
            pass2_reg      <= 1'b0;
            a_reg          <= '0;
            b_reg          <= '0;
            top_reg        <= '0;
            und_reg        <= 1'b0;
            last_reg       <= 1'b0;
            n_reg          <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
        end
        else
        begin
            fwd_rvld_reg <= fwd_rv_reg[fwd_raddr];
            rev_rvld_reg <= rev_rv_reg[rev_raddr];
            if (cfg_we)
            begin
                case (cfg_index)
                    scc_pkg::REG_NODE_COUNT: node_count_reg <= cfg_data;
                    scc_pkg::REG_UNDIRECTED: undirected_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (out_valid_reg && count_out.ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (edge_in.valid)
                    begin
                        a_reg      <= NW'(edge_in.edge_src);
                        b_reg      <= NW'(edge_in.edge_dst);
                        last_reg   <= edge_in.last_edge;
                        und_reg    <= undirected_reg;
                        second_reg <= 1'b0;
                        if (edge_ok)
                        begin
                            state_reg <= S_LRD;
                        end
                        else if (edge_in.last_edge)
                        begin
                            state_reg <= S_CINIT;
                        end
                    end
                end
                S_LRD: state_reg <= S_LWR;
                S_LWR:
                begin
                    fwd_rv_reg[a_reg] <= 1'b1;
                    rev_rv_reg[b_reg] <= 1'b1;
                    if (und_reg && !second_reg)
                    begin
                        a_reg      <= b_reg;
                        b_reg      <= a_reg;
                        second_reg <= 1'b1;
                        state_reg  <= S_LRD;
                    end
                    else if (last_reg)
                    begin
                        state_reg <= S_CINIT;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_CINIT:
                begin
                    n_reg       <= (32'(node_count_reg) > MAX_NODES) ? CW'(MAX_NODES)
                                                                      : CW'(node_count_reg);
                    visited_reg <= '0;
                    fc_reg      <= '0;
                    i_reg       <= '0;
                    pass2_reg   <= 1'b0;
                    state_reg   <= S_P1;
                end
                S_P1:
                begin
                    if (i_reg == n_reg)
                    begin
                        visited_reg <= '0;
                        tree_reg    <= '0;
                        j_reg       <= '0;
                        pass2_reg   <= 1'b1;
                        state_reg   <= S_P2;
                    end
                    else if (visited_reg[NW'(i_reg)])
                    begin
                        i_reg <= i_reg + CW'(1);
                    end
                    else
                    begin
                        visited_reg[NW'(i_reg)] <= 1'b1;
                        top_reg   <= NW'(i_reg);
                        depth_reg <= CW'(1);
                        state_reg <= S_ROW;
                    end
                end
                S_ROW: state_reg <= S_SCAN;
                S_SCAN:
                begin
                    if (found && 32'(depth_reg) < MAX_NODES)
                    begin
                        visited_reg[low_idx] <= 1'b1;
                        top_reg   <= low_idx;
                        depth_reg <= depth_reg + CW'(1);
                        state_reg <= S_ROW;
                    end
                    else
                    begin
                        if (!pass2_reg && 32'(fc_reg) < MAX_NODES)
                        begin
                            fc_reg <= fc_reg + CW'(1);
                        end
                        depth_reg <= depth_reg - CW'(1);
                        if (depth_reg == CW'(1))
                        begin
                            if (pass2_reg)
                            begin
                                j_reg     <= j_reg + CW'(1);
                                state_reg <= S_P2;
                            end
                            else
                            begin
                                i_reg     <= i_reg + CW'(1);
                                state_reg <= S_P1;
                            end
                        end
                        else
                        begin
                            state_reg <= S_POP;
                        end
                    end
                end
                S_POP:
                begin
                    top_reg   <= stack_rdata_reg;
                    state_reg <= S_ROW;
                end
                S_P2:
                begin
                    if (j_reg == fc_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_P2W;
                    end
                end
                S_P2W:
                begin
                    if (visited_reg[finish_rdata_reg])
                    begin
                        j_reg     <= j_reg + CW'(1);
                        state_reg <= S_P2;
                    end
                    else
                    begin
                        tree_reg  <= tree_reg + CW'(1);
                        visited_reg[finish_rdata_reg] <= 1'b1;
                        top_reg   <= finish_rdata_reg;
                        depth_reg <= CW'(1);
                        state_reg <= S_ROW;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || count_out.ready)
                    begin
                        out_count_reg <= scc_pkg::COUNT_W'(tree_reg);
                        out_valid_reg <= 1'b1;
                        fwd_rv_reg    <= '0;
                        rev_rv_reg    <= '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// File: rtl/core/scc_checker.sv
// Port-level checks for the SCC counter top level, with its bind statement.
// Depends on strongly_connected_component_count_top and scc_pkg.
module scc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [scc_pkg::COUNT_W-1:0] out_count
);
    a_reset_clears_out: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("count beat valid during reset");

    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_count))
        else $error("stalled count beat changed");

    a_count_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("count beat appeared while edge input was idle");
endmodule

bind strongly_connected_component_count_top scc_checker u_scc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (edge_in.ready),
    .out_valid (count_out.valid),
    .out_ready (count_out.ready),
    .out_count (count_out.component_count)
);
